### design/frc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FIFO-replacement key/value cache.
// No dependencies; imported by the channel interfaces, the cell and the top level.
package frc_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int EVC_W    = 32;
    localparam int OCC_W    = 5;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [EVC_W-1:0]        evc_t;
    typedef logic [OCC_W-1:0]        occ_t;
    typedef logic [CNT_W-1:0]        cnt_t;

endpackage

### design/frc_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for lookup words and result words.
// Depends on frc_pkg.
interface frc_req_if;
    import frc_pkg::*;

    logic         valid;
    logic         ready;
    logic [0:0]   operation;
    key_t         key;
    val_t         fill_value;

    modport source (output valid, output operation, output key, output fill_value,
                    input ready);
    modport sink   (input valid, input operation, input key, input fill_value,
                    output ready);
endinterface

interface frc_rsp_if;
    import frc_pkg::*;

    logic         valid;
    logic         ready;
    logic         hit;
    val_t         value;
    logic         evicted;
    evc_t         eviction_count;
    occ_t         occupancy;

    modport source (output valid, output hit, output value, output evicted,
                    output eviction_count, output occupancy, input ready);
    modport sink   (input valid, input hit, input value, input evicted,
                    input eviction_count, input occupancy, output ready);
endinterface

### design/frc_cell.sv
`timescale 1ns / 1ps
// One entry of the cache row: holds a key/value pair, compares it with the
// lookup key and hands it to the next-older cell on a shift. Depends on frc_pkg.
module frc_cell (
    input  logic          clk,
    input  logic          shift,
    input  logic          live,
    input  frc_pkg::key_t lookup_key,
    input  frc_pkg::key_t key_in,
    input  frc_pkg::val_t value_in,
    output frc_pkg::key_t key_out,
    output frc_pkg::val_t value_out,
    output logic          match,
    output frc_pkg::val_t match_value
);
    import frc_pkg::*;

    key_t key_reg;
    val_t value_reg;

    // Advance the pair one place down the row
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg   <= key_in;
            value_reg <= value_in;
        end
    end

    assign key_out     = key_reg;
    assign value_out   = value_reg;
    assign match       = live && (key_reg == lookup_key);
    assign match_value = match ? value_reg : '0;

endmodule

### design/fifo_replacement_cache.sv
`timescale 1ns / 1ps
// Fully associative key/value cache, FIFO replacement, built as a row of cells.
// Latency: a result word is valid the cycle after its lookup word is accepted.
// Throughput: one word per cycle unless the sink stalls; every cell compares the key
// combinationally and the row shifts on accept; one result register feeds the sink.
// Reset: entry count, eviction counter and result valid clear; cell contents stay
// undefined and are never read until written.
module fifo_replacement_cache (
    input  logic clk,
    input  logic rst_n,
    frc_req_if.sink   req,
    frc_rsp_if.source rsp
);
    import frc_pkg::*;

    // Entry count and eviction counter
    cnt_t count_reg;
    cnt_t count_next;
    evc_t evc_reg;
    evc_t evc_next;

    // Result register
    logic rsp_valid_reg;
    logic hit_reg;
    val_t value_reg;
    logic evicted_reg;

    // Cell row: cell 0 holds the newest entry, cell CAPACITY-1 the oldest
    key_t                cell_key   [CAPACITY];
    val_t                cell_value [CAPACITY];
    val_t                cell_mval  [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    logic accept;
    logic is_clear;
    logic hit_any;
    logic full;
    logic shift;
    logic evict;
    val_t hit_value;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_clear  = (op_t'(req.operation) == OP_CLEAR);
    assign full      = (count_reg == CNT_W'(CAPACITY));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            key_t key_src;
            val_t value_src;

            // The newest entry enters at the head; every other cell takes its neighbor's pair
            if (gi == 0)
            begin : g_head
                assign key_src   = req.key;
                assign value_src = req.fill_value;
            end
            else
            begin : g_body
                assign key_src   = cell_key[gi-1];
                assign value_src = cell_value[gi-1];
            end

            frc_cell u_cell (
                .clk         (clk),
                .shift       (shift),
                .live        (count_reg > CNT_W'(gi)),
                .lookup_key  (req.key),
                .key_in      (key_src),
                .value_in    (value_src),
                .key_out     (cell_key[gi]),
                .value_out   (cell_value[gi]),
                .match       (match_vec[gi]),
                .match_value (cell_mval[gi])
            );
        end
    endgenerate

    // Keys are unique among live cells, so an OR of gated values selects the hit
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_value = hit_value | cell_mval[i];
        end
    end

    assign hit_any = |match_vec;

    // A miss shifts the row; when full, the oldest pair drops off the tail
    assign shift = accept && !is_clear && !hit_any;
    assign evict = shift && full;

    always_comb
    begin
        count_next = count_reg;
        evc_next   = evc_reg;
        if (accept && is_clear)
        begin
            count_next = '0;
            evc_next   = '0;
        end
        else if (shift)
        begin
            if (full)
            begin
                // Hold the count; bump evictions unless saturated
                if (evc_reg != '1)
                begin
                    evc_next = evc_reg + EVC_W'(1);
                end
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            evc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            evc_reg   <= evc_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while the sink stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg     <= !is_clear && hit_any;
            evicted_reg <= evict;
            if (is_clear)
            begin
                value_reg <= '0;
            end
            else if (hit_any)
            begin
                value_reg <= hit_value;
            end
            else
            begin
                value_reg <= req.fill_value;
            end
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = hit_reg;
    assign rsp.value          = value_reg;
    assign rsp.evicted        = evicted_reg;
    assign rsp.eviction_count = evc_reg;
    assign rsp.occupancy      = OCC_W'(count_reg);

`ifndef SYNTHESIS
    // At most one live cell may match: the row never holds a key twice
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("multiple cells matched one key");

    // The row never claims more entries than it has cells
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // An eviction only happens on a full row, which stays full
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && evicted_reg |-> full)
        else $error("eviction reported with row not full");

    // A hit leaves the entry count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_clear && hit_any |=> count_reg == $past(count_reg))
        else $error("entry count moved on a hit");
`endif

endmodule
